/* hw/rtl/sdiv_pkg.sv */
`default_nettype none
package sdiv_pkg;
  localparam int unsigned NumWidth = 64;
  localparam int unsigned DenWidth = 32;
  localparam int unsigned NumCells = NumWidth;

  typedef struct packed {
    logic                n_neg;
    logic                q_neg;
    logic                zero;
    logic                ovf;
  } sdiv_flags_t;
endpackage
`default_nettype wire

/* hw/rtl/sdiv_cell.sv */
`default_nettype none
module sdiv_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   hold,
  input  logic [sdiv_pkg::NumWidth-1:0]          in_num,
  input  logic [sdiv_pkg::DenWidth:0]            in_rem,
  input  logic [sdiv_pkg::DenWidth-1:0]          in_den,
  input  sdiv_pkg::sdiv_flags_t                  in_flags,
  output logic                                   out_valid,
  output logic [sdiv_pkg::NumWidth-1:0]          out_num,
  output logic [sdiv_pkg::DenWidth:0]            out_rem,
  output logic [sdiv_pkg::DenWidth-1:0]          out_den,
  output sdiv_pkg::sdiv_flags_t                  out_flags
);
  import sdiv_pkg::*;

  logic [DenWidth+1:0] trial;
  logic [DenWidth+1:0] diff;
  logic                take;

  // shift in next dividend bit, try subtract
  assign trial = {in_rem, in_num[NumWidth-1]};
  assign diff  = trial - {2'b00, in_den};
  assign take  = !diff[DenWidth+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      out_num   <= {in_num[NumWidth-2:0], take};
      out_rem   <= take ? diff[DenWidth:0] : trial[DenWidth:0];
      out_den   <= in_den;
      out_flags <= in_flags;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/signed_divider_64_by_32_core.sv */
`default_nettype none
// Pipelined signed 64/32 divider: one request accepted per cycle while the output
// is not held; each result passes one input stage for magnitudes, 64
// restoring-division cells of one quotient bit each and one output stage for sign
// fix-up. Quotient truncates toward zero, remainder takes the dividend's sign.
// Zero divisor gives zero results with div_by_zero set; most negative over -1
// wraps with overflowed set. The whole pipe stalls while the output request is held.
module signed_divider_64_by_32_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sdiv_pkg::NumWidth-1:0]  dividend,
  input  logic signed [sdiv_pkg::DenWidth-1:0]  divisor,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sdiv_pkg::NumWidth-1:0]  quotient,
  output logic signed [sdiv_pkg::DenWidth-1:0]  remainder,
  output logic                                  div_by_zero,
  output logic                                  overflowed
);
  import sdiv_pkg::*;

  logic                 hold;
  logic                 v   [NumCells+1];
  logic [NumWidth-1:0]  num [NumCells+1];
  logic [DenWidth:0]    rem [NumCells+1];
  logic [DenWidth-1:0]  den [NumCells+1];
  sdiv_flags_t          flg [NumCells+1];
  sdiv_flags_t          f_in;
  logic [NumWidth-1:0]  q_mag;
  logic [DenWidth-1:0]  r_mag;

  assign hold     = out_valid && !out_ready;
  assign in_ready = !hold;

  assign f_in.n_neg = dividend[NumWidth-1];
  assign f_in.q_neg = dividend[NumWidth-1] ^ divisor[DenWidth-1];
  assign f_in.zero  = divisor == '0;
  assign f_in.ovf   = (dividend == {1'b1, {(NumWidth-1){1'b0}}}) && (divisor == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (!hold) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      num[0] <= dividend[NumWidth-1] ? NumWidth'(-dividend) : dividend;
      den[0] <= divisor[DenWidth-1] ? DenWidth'(-divisor) : divisor;
      rem[0] <= '0;
      flg[0] <= f_in;
    end
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    sdiv_cell u_cell (
      .clk(clk), .rst(rst), .in_valid(v[i]), .hold(hold),
      .in_num(num[i]), .in_rem(rem[i]), .in_den(den[i]), .in_flags(flg[i]),
      .out_valid(v[i+1]), .out_num(num[i+1]), .out_rem(rem[i+1]),
      .out_den(den[i+1]), .out_flags(flg[i+1])
    );
  end

  assign q_mag = num[NumCells];
  assign r_mag = rem[NumCells][DenWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= v[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      div_by_zero <= flg[NumCells].zero;
      overflowed  <= flg[NumCells].ovf && !flg[NumCells].zero;
      if (flg[NumCells].zero) begin
        quotient  <= '0;
        remainder <= '0;
      end else begin
        quotient  <= flg[NumCells].q_neg ? NumWidth'(-q_mag) : q_mag;
        remainder <= flg[NumCells].n_neg ? DenWidth'(-r_mag) : r_mag;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/sdiv_checker.sv */
`default_nettype none
module sdiv_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [sdiv_pkg::NumWidth-1:0] quotient,
  input logic signed [sdiv_pkg::DenWidth-1:0] remainder,
  input logic                                 div_by_zero,
  input logic                                 overflowed
);
  import sdiv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient))
    else $error("output request dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> quotient == '0 && remainder == '0 && !overflowed)
    else $error("zero divisor result");
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflowed |-> remainder == '0 && quotient[NumWidth-1])
    else $error("overflow result");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stall without output");
endmodule

bind signed_divider_64_by_32_core sdiv_checker u_sdiv_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .quotient(quotient), .remainder(remainder),
  .div_by_zero(div_by_zero), .overflowed(overflowed)
);
`default_nettype wire

/* test/tb_signed_divider_64_by_32_core.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_signed_divider_64_by_32_core;
  import sdiv_pkg::*;

  localparam int unsigned PipeDepth = 66;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic signed [NumWidth-1:0] quo;
    logic signed [DenWidth-1:0] rem;
    logic                       dbz;
    logic                       ovf;
  } div_result_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [NumWidth-1:0] dividend;
  logic signed [DenWidth-1:0] divisor;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [NumWidth-1:0] quotient;
  logic signed [DenWidth-1:0] remainder;
  logic                       div_by_zero;
  logic                       overflowed;

  div_result_t pending_quotients[$];
  int          n_errors;
  int          n_results;
  int          n_dbz;
  int          n_ovf;
  int          idle_cycles;
  bit          hold_off;
  bit          stall_on;

  signed_divider_64_by_32_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .dividend(dividend), .divisor(divisor),
    .out_valid(out_valid), .out_ready(out_ready),
    .quotient(quotient), .remainder(remainder),
    .div_by_zero(div_by_zero), .overflowed(overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic div_result_t divide_truncating(logic [NumWidth-1:0] n,
                                                    logic [DenWidth-1:0] d);
    div_result_t res;
    logic [NumWidth-1:0] n_mag;
    logic [NumWidth-1:0] d_mag;
    logic [NumWidth-1:0] q;
    logic [NumWidth-1:0] r;
    logic [NumWidth-1:0] r_s;
    logic                n_neg;
    logic                d_neg;
    res = '0;
    if (d == '0) begin
      res.dbz = 1'b1;
      return res;
    end
    n_neg = n[NumWidth-1];
    d_neg = d[DenWidth-1];
    n_mag = n_neg ? -n : n;
    d_mag = d_neg ? {32'd0, -d} : {32'd0, d};
    q = n_mag / d_mag;
    r = n_mag % d_mag;
    r_s = n_neg ? -r : r;
    res.quo = (n_neg != d_neg) ? -q : q;
    res.rem = r_s[DenWidth-1:0];
    res.ovf = (n == {1'b1, 63'd0}) && (d == '1);
    return res;
  endfunction

  task automatic send_division(logic [NumWidth-1:0] n, logic [DenWidth-1:0] d);
    in_valid <= 1'b1;
    dividend <= n;
    divisor  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_quotients.push_back(divide_truncating(n, d));
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [NumWidth-1:0] rand_dividend();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
      2: return {{48{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      3: return $urandom_range(0, 1) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [DenWidth-1:0] rand_divisor();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom)};
      4: return 32'sd1 <<< $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed_edges();
    logic [NumWidth-1:0] ns[7];
    logic [DenWidth-1:0] ds[4];
    ns = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'd0, 64'd1,
           '1, 64'd7, -64'sd7};
    ds = '{32'h8000_0000, 32'h7fff_ffff, '1, 32'd2};
    foreach (ns[i]) send_division(ns[i], '0);
    send_division(64'h8000_0000_0000_0000, '1);
    foreach (ds[j]) begin
      send_division(ns[0], ds[j]);
      send_division(ns[1], ds[j]);
      send_division(ns[5], ds[j]);
      send_division(ns[6], ds[j]);
    end
    drop_valid();
  endtask

  task automatic run_random_bursts(int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_division(rand_dividend(), rand_divisor());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    drop_valid();
  endtask

  task automatic run_backpressure_fill();
    hold_off <= 1'b1;
    repeat (150) send_division(rand_dividend(), rand_divisor());
    drop_valid();
  endtask

  task automatic wait_for_drain();
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  initial begin : backpressure_hold
    int k;
    @(posedge hold_off);
    for (k = 0; k < 300; k++) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_on  <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 3) stall_on <= ~stall_on;
      out_ready <= !hold_off && !(stall_on && $urandom_range(0, 1));
    end
  end

  always @(posedge clk) begin
    div_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_quotients.size() == 0) begin
        $error("result with no pending request: q=%0d", quotient);
        n_errors++;
      end else begin
        want = pending_quotients.pop_front();
        n_results++;
        if (quotient !== want.quo) begin
          $error("quotient: expected %0d, got %0d", want.quo, quotient);
          n_errors++;
        end
        if (remainder !== want.rem) begin
          $error("remainder: expected %0d, got %0d", want.rem, remainder);
          n_errors++;
        end
        if (div_by_zero !== want.dbz) begin
          $error("div_by_zero: expected %0b, got %0b", want.dbz, div_by_zero);
          n_errors++;
        end
        if (overflowed !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
          n_errors++;
        end
        n_dbz += want.dbz;
        n_ovf += want.ovf;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no progress for %0d cycles", IdleLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    n_errors    = 0;
    n_results   = 0;
    n_dbz       = 0;
    n_ovf       = 0;
    idle_cycles = 0;
    hold_off    = 1'b0;
    stall_on    = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    dividend    = '0;
    divisor     = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed_edges();
    run_backpressure_fill();
    run_random_bursts(1400);
    wait_for_drain();
    $display("checked %0d divisions, %0d by zero, %0d overflowed,", n_results, n_dbz,
             n_ovf);
    $display("under bursty input, random output stalls and one long hold-off");
    if (n_errors == 0 && pending_quotients.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
